/* hw/rtl/stf_pkg.sv */
package stf_pkg;

   // input item: one display update request
   typedef struct packed {
      logic [13:0] speed_value;
      logic [12:0] time_seconds;
      logic        speed_editing;
      logic        time_editing;
      logic        keys_idle;
      logic        point_on;
   } req_type;

   // result item: one display RAM write
   typedef struct packed {
      logic [3:0] lcd_address;
      logic [7:0] segment_byte;
      logic       last_write;
   } rsp_type;

   // formatted bytes of one update, handed from front to back
   typedef struct packed {
      logic [7:0] spd_hi;
      logic [7:0] spd_mid;
      logic [7:0] spd_lo;
      logic [7:0] tim_tens;
      logic [7:0] units_pat;
      logic [7:0] final_byte;
   } item_type;

   localparam logic [13:0] SPEED_MAX = 14'd9999;
   localparam logic [12:0] TIME_MAX  = 13'd5999;
   localparam logic [12:0] SECS_PER_MIN = 13'd60;

   // reciprocal constants: x/10 = (x*6554)>>16 for x < 10000,
   // x/60 = (x*17477)>>20 for x < 6000, x/100 = (x*656)>>16 for x < 1000,
   // x/10 = (x*205)>>11 for x < 100
   localparam logic [12:0] RECIP_10_S16  = 13'd6554;
   localparam logic [14:0] RECIP_60_S20  = 15'd17477;
   localparam logic [9:0]  RECIP_100_S16 = 10'd656;
   localparam logic [7:0]  RECIP_10_S11  = 8'd205;

   localparam logic [7:0] TENS_MARK   = 8'h80;
   localparam logic [7:0] HI_NIBBLE   = 8'hf0;
   localparam logic [7:0] LO_NIBBLE   = 8'h0f;
   localparam logic [7:0] CLR_SEC_BIT = 8'hf7;
   localparam logic [7:0] CLR_MIN_BIT = 8'hfe;
   localparam logic [7:0] CLR_POINT   = 8'h7f;
   localparam logic [7:0] SET_SEC_BIT = 8'h01;
   localparam logic [7:0] SET_MIN_BIT = 8'h08;
   localparam logic [7:0] SET_POINT   = 8'h80;

   // display RAM addresses
   localparam logic [3:0] ADDR_SPD_HI   = 4'h0;
   localparam logic [3:0] ADDR_SPD_MID  = 4'h2;
   localparam logic [3:0] ADDR_SPD_LO   = 4'h4;
   localparam logic [3:0] ADDR_TIM_TENS = 4'h6;
   localparam logic [3:0] ADDR_TIM_UNIT = 4'h8;
   localparam logic [3:0] ADDR_TIM_LOW  = 4'ha;

   // write sequence steps
   localparam logic [2:0] STEP_SPD_HI   = 3'd0;
   localparam logic [2:0] STEP_SPD_MID  = 3'd1;
   localparam logic [2:0] STEP_SPD_LO   = 3'd2;
   localparam logic [2:0] STEP_TIM_TENS = 3'd3;
   localparam logic [2:0] STEP_TIM_UNIT = 3'd4;
   localparam logic [2:0] STEP_TIM_LOW  = 3'd5;
   localparam logic [2:0] STEP_FINAL    = 3'd6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SEG_TABLE [10] = '{
      8'h5f, 8'h06, 8'h3d, 8'h2f, 8'h66, 8'h6b, 8'h7b, 8'h0e, 8'h7f, 8'h6f
   };

   function automatic logic [7:0] seg_encode(input logic [3:0] digit);
      logic [7:0] pat;
      if (digit < 4'd10) begin
         pat = SEG_TABLE[digit];
      end else begin
         pat = 8'h00;
      end
      return pat;
   endfunction

   // two decimal digits {tens, units} of a value below 100
   function automatic logic [7:0] split99(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [7:0]  units;
      prod  = 15'(value) * 15'(RECIP_10_S11);
      tens  = prod[14:11];
      units = 8'(value) - 8'(tens) * 8'd10;
      return {tens, units[3:0]};
   endfunction

endpackage

/* hw/rtl/stf_front.sv */
module stf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stf_pkg::req_type   req_data,
   output logic               push_valid,
   input  logic               push_ready,
   output stf_pkg::item_type  push_data
);

   logic        advance;
   logic [13:0] spd_clamp;
   logic [12:0] tim_clamp;
   logic [26:0] spd_prod;
   logic [27:0] tim_prod;
   logic        minutes;
   logic [6:0]  tim_val;

   logic        v1_ff, v1_in;
   logic [9:0]  sq1_ff;
   logic [6:0]  tval1_ff;
   logic        min1_ff, spb1_ff, tmb1_ff, pt1_ff;

   logic        v2_ff, v2_in;
   logic [9:0]  sq2_ff;
   logic [3:0]  hund2_ff;
   logic [7:0]  tdig2_ff;
   logic        min2_ff, spb2_ff, tmb2_ff, pt2_ff;

   logic [25:0] hund_prod;
   logic [9:0]  spd_rem;
   logic [7:0]  sdig;
   logic [7:0]  u_pat;
   logic [7:0]  tens_pat;
   logic [7:0]  fin_mode;

   // whole pipeline moves together when its last stage can drain
   assign advance   = !v2_ff || push_ready;
   assign req_ready = advance;

   // stage 1: clamp and scale
   always_comb begin
      spd_clamp = (req_data.speed_value > stf_pkg::SPEED_MAX) ?
                  stf_pkg::SPEED_MAX : req_data.speed_value;
      tim_clamp = (req_data.time_seconds > stf_pkg::TIME_MAX) ?
                  stf_pkg::TIME_MAX : req_data.time_seconds;
      spd_prod  = 27'(spd_clamp) * 27'(stf_pkg::RECIP_10_S16);
      tim_prod  = 28'(tim_clamp) * 28'(stf_pkg::RECIP_60_S20);
      minutes   = tim_clamp >= stf_pkg::SECS_PER_MIN;
      tim_val   = minutes ? tim_prod[26:20] : tim_clamp[6:0];
   end

   assign v1_in = advance ? (req_valid && req_ready) : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq1_ff   <= spd_prod[25:16];
         tval1_ff <= tim_val;
         min1_ff  <= minutes;
         spb1_ff  <= req_data.speed_editing && req_data.keys_idle;
         tmb1_ff  <= req_data.time_editing && req_data.keys_idle;
         pt1_ff   <= req_data.point_on;
      end
   end

   // stage 2: hundreds digit of speed/10, time digits
   assign hund_prod = 26'(sq1_ff) * 26'(stf_pkg::RECIP_100_S16);

   always_ff @(posedge clock) begin
      if (advance) begin
         sq2_ff   <= sq1_ff;
         hund2_ff <= hund_prod[19:16];
         tdig2_ff <= stf_pkg::split99(tval1_ff);
         min2_ff  <= min1_ff;
         spb2_ff  <= spb1_ff;
         tmb2_ff  <= tmb1_ff;
         pt2_ff   <= pt1_ff;
      end
   end

   // encode: remaining speed digits, segment patterns, mode byte
   always_comb begin
      spd_rem  = sq2_ff - 10'(hund2_ff) * 10'd100;
      sdig     = stf_pkg::split99(spd_rem[6:0]);
      u_pat    = tmb2_ff ? 8'h00 : stf_pkg::seg_encode(tdig2_ff[3:0]);
      tens_pat = tmb2_ff ? 8'h00 : stf_pkg::seg_encode(tdig2_ff[7:4]);
      if (min2_ff) begin
         fin_mode = (u_pat | stf_pkg::SET_MIN_BIT) & stf_pkg::CLR_MIN_BIT;
      end else begin
         fin_mode = (u_pat | stf_pkg::SET_SEC_BIT) & stf_pkg::CLR_SEC_BIT;
      end
      push_data.spd_hi   = spb2_ff ? 8'h00 : stf_pkg::seg_encode(hund2_ff);
      push_data.spd_mid  = spb2_ff ? 8'h00 : stf_pkg::seg_encode(sdig[7:4]);
      push_data.spd_lo   = spb2_ff ? 8'h00 : stf_pkg::seg_encode(sdig[3:0]);
      push_data.tim_tens = tens_pat | stf_pkg::TENS_MARK;
      push_data.units_pat = u_pat;
      push_data.final_byte = pt2_ff ? (fin_mode & stf_pkg::CLR_POINT) :
                                      (fin_mode | stf_pkg::SET_POINT);
   end

   assign push_valid = v2_ff;

endmodule

/* hw/rtl/stf_queue.sv */
module stf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  stf_pkg::item_type  push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output stf_pkg::item_type  pop_data
);

   stf_pkg::item_type entry_ff [stf_pkg::QUEUE_DEPTH];

   logic [stf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   localparam logic [stf_pkg::QPTR_W-1:0] LAST_PTR =
      stf_pkg::QPTR_W'(stf_pkg::QUEUE_DEPTH - 1);
   localparam logic [stf_pkg::QCNT_W-1:0] FULL_COUNT =
      stf_pkg::QCNT_W'(stf_pkg::QUEUE_DEPTH);

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // occupancy never exceeds the storage
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count overflow");

   // pointers agree with occupancy when empty or full
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step with count");
`endif

endmodule

/* hw/rtl/stf_back.sv */
module stf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  stf_pkg::item_type  pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stf_pkg::rsp_type   rsp_data
);

   logic [2:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   stf_pkg::rsp_type  rsp_ff, rsp_in;
   logic              load;

   assign load      = (!rsp_valid_ff || rsp_ready) && pop_valid;
   assign pop_ready = (!rsp_valid_ff || rsp_ready) && (step_ff == stf_pkg::STEP_FINAL);

   always_comb begin
      rsp_in.last_write = step_ff == stf_pkg::STEP_FINAL;
      case (step_ff)
         stf_pkg::STEP_SPD_HI: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_SPD_HI;
            rsp_in.segment_byte = pop_data.spd_hi;
         end
         stf_pkg::STEP_SPD_MID: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_SPD_MID;
            rsp_in.segment_byte = pop_data.spd_mid;
         end
         stf_pkg::STEP_SPD_LO: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_SPD_LO;
            rsp_in.segment_byte = pop_data.spd_lo;
         end
         stf_pkg::STEP_TIM_TENS: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_TIM_TENS;
            rsp_in.segment_byte = pop_data.tim_tens;
         end
         stf_pkg::STEP_TIM_UNIT: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_TIM_UNIT;
            rsp_in.segment_byte = pop_data.units_pat & stf_pkg::HI_NIBBLE;
         end
         stf_pkg::STEP_TIM_LOW: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_TIM_LOW;
            rsp_in.segment_byte = (pop_data.units_pat & stf_pkg::LO_NIBBLE) << 4;
         end
         stf_pkg::STEP_FINAL: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_TIM_UNIT;
            rsp_in.segment_byte = pop_data.final_byte;
         end
         default: begin
            rsp_in.lcd_address  = stf_pkg::ADDR_SPD_HI;
            rsp_in.segment_byte = 8'h00;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         step_in      = (step_ff == stf_pkg::STEP_FINAL) ? stf_pkg::STEP_SPD_HI :
                                                           step_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= stf_pkg::STEP_SPD_HI;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // sequencer never leaves the seven write steps
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= stf_pkg::STEP_FINAL)
      else $error("write step out of range");

   // the closing write always goes to the units/mode address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_write |-> rsp_ff.lcd_address == stf_pkg::ADDR_TIM_UNIT)
      else $error("last write at wrong address");

   // an item leaves the queue only together with its closing write
   assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |-> load && rsp_in.last_write)
      else $error("queue entry dropped before all writes sent");
`endif

endmodule

/* hw/rtl/speed_time_segment_formatter.sv */
// speed/time seven-segment formatter: each request transfer (speed, time,
// edit and idle flags, point flag) yields seven display RAM write transfers
// in fixed order: speed hundreds, tens, units of speed/10 at 0x0, 0x2, 0x4;
// time tens at 0x6; units high nibble at 0x8; units low nibble at 0xa; and
// the mode/point byte at 0x8 again, flagged by last_write. speed is clamped
// to 9999 and time to 5999; time shows seconds below 60 s, minutes from 60 s up.
// throughput is set by the write sequencer, which emits one write per cycle
// while its output is not back-pressured and the queue holds an item; a
// request is registered in the formatter pipeline before it enters the queue,
// and its writes are presented from the sequencer's output register. a
// two-entry queue between formatter and sequencer lets new requests be taken
// while writes of earlier ones are still going out. no state is kept between
// requests and there is no configuration.
module speed_time_segment_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stf_pkg::rsp_type  rsp_data
);

   // formatter to queue
   logic              push_valid;
   logic              push_ready;
   stf_pkg::item_type push_data;

   // queue to write sequencer
   logic              pop_valid;
   logic              pop_ready;
   stf_pkg::item_type pop_data;

   // front: clamp, digit split and segment encoding, pipelined
   stf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // short queue of formatted updates
   stf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: seven-step write sequencer with registered output
   stf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
